/* sv/ntpr_pkg.sv */
// ----------------------------------------------------------------------------
// ntpr_pkg
// Shared constants, codes and request types of the pattern replace core.
// ----------------------------------------------------------------------------
package ntpr_pkg;

    localparam int NUM_PAIRS       = 4;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int COUNT_WIDTH     = 16;

    localparam int WIN_LEN     = MAX_PATTERN_LEN + 1;
    localparam int FILL_W      = $clog2(WIN_LEN + 1);
    localparam int SLOT_W      = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int PAIR_W      = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request type codes on the input channel
    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_PATTERN = 2'd1;
    localparam logic [1:0] REQ_REPLACE = 2'd2;

    // classified kinds carried through the queue
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_PATTERN = 2'd1;
    localparam logic [1:0] KIND_REPLACE = 2'd2;

    // result kinds
    localparam logic OUT_BYTE  = 1'b0;
    localparam logic OUT_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] entry_index;
        logic [5:0] byte_pos;
        logic [7:0] byte_value;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [15:0] match_count;
        logic        is_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAIR_W-1:0] entry;
        logic [SLOT_W-1:0] pos;
        logic [7:0]        value;
        logic              last;
    } t_q_item;

endpackage

/* sv/ntpr_front.sv */
// ----------------------------------------------------------------------------
// ntpr_front
// Accepts requests, drops unknown ones and bad load addresses, registers
// the classified request and hands it to the queue.
// ----------------------------------------------------------------------------
module ntpr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ntpr_pkg::t_in_item i_in_data,
    output logic               o_push,
    output ntpr_pkg::t_q_item  o_push_item,
    input  logic               i_q_full
);
    import ntpr_pkg::*;

    logic    r_valid, n_valid;
    t_q_item r_item, n_item;
    logic    accept, keep;
    logic    addr_ok;

    assign o_in_stall  = r_valid && i_q_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_q_full;
    assign o_push_item = r_item;

    assign addr_ok = (int'(i_in_data.entry_index) < NUM_PAIRS) &&
                     (int'(i_in_data.byte_pos) <= MAX_PATTERN_LEN);

    always_comb begin
        n_item.entry = PAIR_W'(i_in_data.entry_index);
        n_item.pos   = SLOT_W'(i_in_data.byte_pos);
        n_item.value = i_in_data.byte_value;
        n_item.last  = 1'b0;
        case (i_in_data.req_type)
            REQ_DATA: begin
                keep         = 1'b1;
                n_item.kind  = KIND_DATA;
                n_item.last  = i_in_data.end_of_buffer;
            end
            REQ_PATTERN: begin
                keep        = addr_ok;
                n_item.kind = KIND_PATTERN;
            end
            REQ_REPLACE: begin
                keep        = addr_ok;
                n_item.kind = KIND_REPLACE;
            end
            default: begin
                keep        = 1'b0;
                n_item.kind = KIND_DATA;
            end
        endcase
        n_valid = accept ? keep : (r_valid && i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* sv/ntpr_queue.sv */
// ----------------------------------------------------------------------------
// ntpr_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
module ntpr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ntpr_pkg::t_q_item i_push_item,
    output logic              o_full,
    output logic              o_valid,
    output ntpr_pkg::t_q_item o_item,
    input  logic              i_pop
);
    import ntpr_pkg::*;

    t_q_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

/* sv/ntpr_back.sv */
// ----------------------------------------------------------------------------
// ntpr_back
// Pattern tables, byte window with parallel comparators, replacement,
// end-of-buffer flush and the output register.
// ----------------------------------------------------------------------------
module ntpr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ntpr_pkg::t_q_item   i_q_item,
    output logic                o_q_pop,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ntpr_pkg::t_out_item o_out_data
);
    import ntpr_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic [7:0]             r_pat [NUM_PAIRS][WIN_LEN];
    logic [7:0]             r_rep [NUM_PAIRS][WIN_LEN];
    logic [7:0]             r_win [WIN_LEN];
    logic [7:0]             n_win [WIN_LEN];
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [FILL_W-1:0]      r_skip, n_skip;
    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic [2:0]             r_pairs;
    logic                   r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic              out_free, take, ins, emit, count_out;
    logic [7:0]        src_win [WIN_LEN];
    logic [FILL_W-1:0] src_fill;
    logic [NUM_PAIRS-1:0] hit;
    logic [7:0]        rep_win [NUM_PAIRS][WIN_LEN];
    logic [FILL_W-1:0] pair_len [NUM_PAIRS];
    logic [7:0]        m_win [WIN_LEN];
    logic              m_hit;
    logic [FILL_W-1:0] m_len;

    assign out_free = !r_out_valid || !i_out_stall;

    // a data request that fills the window also sends the head byte out
    assign take = i_q_valid && (r_state == ST_RUN) &&
                  ((i_q_item.kind != KIND_DATA) || i_q_item.last ||
                   (r_fill != FILL_W'(WIN_LEN - 1)) || out_free);
    assign ins  = take && (i_q_item.kind == KIND_DATA);
    assign emit = (ins && !i_q_item.last && (src_fill == FILL_W'(WIN_LEN))) ||
                  ((r_state == ST_FLUSH) && out_free && (r_fill != '0));
    assign count_out = (r_state == ST_FLUSH) && out_free && (r_fill == '0);

    assign o_q_pop     = take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            src_win[i] = (ins && (r_fill == FILL_W'(i))) ? i_q_item.value : r_win[i];
        end
        src_fill = ins ? r_fill + FILL_W'(1) : r_fill;
    end

    // one comparator row per pair against the whole window
    for (genvar e = 0; e < NUM_PAIRS; e++) begin : g_pair
        logic [MAX_PATTERN_LEN-1:0] pnz, rnz, in_pat, rep_live;
        logic [WIN_LEN-1:0]         term, ok;
        logic [FILL_W-1:0]          len_v;

        for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_pre
            assign pnz[i]      = (r_pat[e][i] != 8'd0);
            assign rnz[i]      = (r_rep[e][i] != 8'd0);
            assign in_pat[i]   = &pnz[i:0];
            assign rep_live[i] = &rnz[i:0];
        end

        // term marks the terminator position, one past the pattern
        assign term[0] = 1'b0;
        for (genvar i = 1; i < WIN_LEN; i++) begin : g_term
            if (i == MAX_PATTERN_LEN) begin : g_full
                assign term[i] = in_pat[i-1];
            end else begin : g_part
                assign term[i] = in_pat[i-1] & ~pnz[i];
            end
        end

        for (genvar i = 0; i < WIN_LEN; i++) begin : g_cmp
            if (i < MAX_PATTERN_LEN) begin : g_body
                assign ok[i] = in_pat[i] ? (src_win[i] == r_pat[e][i]) :
                               (!term[i] || ((src_win[i] == 8'd0) &&
                                             (int'(src_fill) > i)));
                assign rep_win[e][i] = in_pat[i] ? (rep_live[i] ? r_rep[e][i] : 8'd0)
                                                 : src_win[i];
            end else begin : g_tail
                assign ok[i] = !term[i] ||
                               ((src_win[i] == 8'd0) && (int'(src_fill) > i));
                assign rep_win[e][i] = src_win[i];
            end
        end

        always_comb begin
            len_v = '0;
            for (int i = 1; i < WIN_LEN; i++) begin
                if (term[i]) begin
                    len_v = len_v | FILL_W'(i);
                end
            end
        end

        assign pair_len[e] = len_v;
        assign hit[e]      = pnz[0] && (&ok) && (e < int'(r_pairs));
    end

    // lowest pair wins; no new match while the previous one drains
    always_comb begin
        m_hit = 1'b0;
        m_len = '0;
        m_win = src_win;
        for (int e = NUM_PAIRS - 1; e >= 0; e--) begin
            if (hit[e] && (r_skip == '0)) begin
                m_hit = 1'b1;
                m_len = pair_len[e];
                m_win = rep_win[e];
            end
        end
    end

    always_comb begin
        n_win       = src_win;
        n_fill      = src_fill;
        n_skip      = r_skip;
        n_total     = r_total;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (emit) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                n_win[i] = m_win[i+1];
            end
            n_win[WIN_LEN-1]  = 8'd0;
            n_fill            = src_fill - FILL_W'(1);
            n_out_valid       = 1'b1;
            n_out.out_kind    = OUT_BYTE;
            n_out.out_byte    = m_win[0];
            n_out.match_count = 16'd0;
            n_out.is_last     = 1'b0;
            if (m_hit) begin
                n_skip = m_len;
                if (r_total != '1) begin
                    n_total = r_total + COUNT_WIDTH'(1);
                end
            end else if (r_skip != '0) begin
                n_skip = r_skip - FILL_W'(1);
            end
        end
        if (ins && i_q_item.last) begin
            n_state = ST_FLUSH;
        end
        if (count_out) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                n_win[i] = 8'd0;
            end
            n_fill            = '0;
            n_skip            = '0;
            n_total           = '0;
            n_state           = ST_RUN;
            n_out_valid       = 1'b1;
            n_out.out_kind    = OUT_COUNT;
            n_out.out_byte    = 8'd0;
            n_out.match_count = 16'(r_total);
            n_out.is_last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= 8'd0;
            end
            r_fill      <= '0;
            r_skip      <= '0;
            r_total     <= '0;
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
            r_pairs     <= 3'd0;
        end else begin
            r_win       <= n_win;
            r_fill      <= n_fill;
            r_skip      <= n_skip;
            r_total     <= n_total;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pairs <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < NUM_PAIRS; e++) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                if (take && (i_q_item.entry == PAIR_W'(e)) &&
                    (i_q_item.pos == SLOT_W'(i))) begin
                    if (i_q_item.kind == KIND_PATTERN) begin
                        r_pat[e][i] <= i_q_item.value;
                    end
                    if (i_q_item.kind == KIND_REPLACE) begin
                        r_rep[e][i] <= i_q_item.value;
                    end
                end
            end
        end
    end

endmodule

/* sv/nul_terminated_pattern_replace_core.sv */
// ----------------------------------------------------------------------------
// nul_terminated_pattern_replace_core
// Streaming in-place replacement of zero-terminated patterns in a buffer.
// ----------------------------------------------------------------------------
// Input channel (valid/stall) carries one request per transfer: a buffer
// data byte, or a load of one pattern or replacement table byte. Output
// channel carries patched buffer bytes in order and, after the byte marked
// end_of_buffer, one count result with is_last set.
// Throughput is one request per cycle while o_in_stall is low; the front
// register and the request queue let requests keep flowing while a
// result waits at the output. A data byte leaves once 32 later bytes have
// arrived (the window holds MAX_PATTERN_LEN+1 bytes). The end of a buffer
// flushes the window at one byte per cycle while the output is not
// stalled, then the count; until then new requests wait in the queue.
// The parallel window comparators decide a match in the cycle the head
// byte goes out. pairs_in_use is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while idle; the block does not enforce it.
// Reset clears the window, counters, queue and pairs_in_use; the tables
// are not cleared and must be loaded before use. When the receiver stalls,
// the output register holds its result and the queue fills, then the
// input stall rises.
// ----------------------------------------------------------------------------
module nul_terminated_pattern_replace_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ntpr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ntpr_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata
);
    import ntpr_pkg::*;

    logic    push, q_full, q_valid, q_pop;
    t_q_item push_item, q_item;

    ntpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_item (push_item),
        .i_q_full    (q_full)
    );

    ntpr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop       (q_pop)
    );

    ntpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* sv/ntpr_checker.sv */
// ----------------------------------------------------------------------------
// ntpr_checker
// Port-level checks of the pattern replace core, bound to the top level.
// ----------------------------------------------------------------------------
module ntpr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ntpr_pkg::t_out_item o_out_data
);
    import ntpr_pkg::*;

    // nothing pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs active after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // byte results and the count result keep their unused fields clear
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.out_kind == o_out_data.is_last) &&
                         ((o_out_data.out_kind == OUT_COUNT) ?
                          (o_out_data.out_byte == 8'd0) :
                          (o_out_data.match_count == 16'd0))))
        else $error("result fields inconsistent with kind");

endmodule

bind nul_terminated_pattern_replace_core ntpr_checker u_ntpr_checker (.*);

/* verif/patch_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// patch_checker
// Watches both channels and the config port of the pattern replace core,
// predicts every patched byte and match count, and compares them in order.
// ----------------------------------------------------------------------------
module patch_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ntpr_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ntpr_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_bytes_checked,
    output int                  o_counts_checked,
    output int                  o_replaced
);
    import ntpr_pkg::*;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

    logic [7:0]      pattern_mem [NUM_PAIRS][WIN_LEN];
    logic [7:0]      subst_mem   [NUM_PAIRS][WIN_LEN];
    logic [7:0]      window_q    [WIN_LEN];
    int              fill_cnt;
    int              skip_cnt;
    longint unsigned replaced_cnt;
    logic [2:0]      pairs_reg;
    t_out_item       want_patched [$];

    // length up to the first zero byte, capped at MAX_PATTERN_LEN here and at limit below
    function automatic int pat_length(input int e);
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (pattern_mem[e][i] == 8'h00) return i;
        end
        return MAX_PATTERN_LEN;
    endfunction

    function automatic int subst_length(input int e, input int limit);
        for (int i = 0; i < limit; i++) begin
            if (subst_mem[e][i] == 8'h00) return i;
        end
        return limit;
    endfunction

    task automatic try_replace();
        int  n;
        int  len;
        int  rlen;
        bit  hit;
        n = (pairs_reg > NUM_PAIRS) ? NUM_PAIRS : int'(pairs_reg);
        for (int e = 0; e < n; e++) begin
            len = pat_length(e);
            // the terminator must already be inside the window
            if (len == 0 || len + 1 > fill_cnt) continue;
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (window_q[i] != pattern_mem[e][i]) hit = 1'b0;
            end
            if (!hit || window_q[len] != 8'h00) continue;
            rlen = subst_length(e, len);
            for (int i = 0; i < len; i++) begin
                window_q[i] = (i < rlen) ? subst_mem[e][i] : 8'h00;
            end
            skip_cnt = len + 1;
            if (replaced_cnt < COUNT_MAX) replaced_cnt++;
            return;
        end
    endtask

    task automatic emit_head();
        t_out_item r;
        if (skip_cnt == 0) try_replace();
        if (skip_cnt > 0) skip_cnt--;
        r          = '0;
        r.out_kind = OUT_BYTE;
        r.out_byte = window_q[0];
        want_patched.push_back(r);
        for (int i = 0; i < WIN_LEN - 1; i++) window_q[i] = window_q[i + 1];
        window_q[WIN_LEN - 1] = 8'h00;
        fill_cnt--;
    endtask

    task automatic clear_buffer_state();
        foreach (window_q[i]) window_q[i] = 8'h00;
        fill_cnt     = 0;
        skip_cnt     = 0;
        replaced_cnt = 0;
    endtask

    task automatic patch_request(input t_in_item it);
        t_out_item r;
        case (it.req_type)
            REQ_PATTERN, REQ_REPLACE: begin
                if (it.entry_index < NUM_PAIRS && it.byte_pos <= MAX_PATTERN_LEN) begin
                    if (it.req_type == REQ_PATTERN)
                        pattern_mem[it.entry_index][it.byte_pos] = it.byte_value;
                    else
                        subst_mem[it.entry_index][it.byte_pos] = it.byte_value;
                end
            end
            REQ_DATA: begin
                if (fill_cnt < WIN_LEN) begin
                    window_q[fill_cnt] = it.byte_value;
                    fill_cnt++;
                end
                if (!it.end_of_buffer) begin
                    if (fill_cnt == WIN_LEN) emit_head();
                end else begin
                    while (fill_cnt > 0) emit_head();
                    r             = '0;
                    r.out_kind    = OUT_COUNT;
                    r.match_count = 16'(replaced_cnt);
                    r.is_last     = 1'b1;
                    want_patched.push_back(r);
                    o_replaced += int'(replaced_cnt);
                    clear_buffer_state();
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        o_fail_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_buffer_state();
            pairs_reg = '0;
            want_patched.delete();
            o_fail_count     = 0;
            o_bytes_checked  = 0;
            o_counts_checked = 0;
            o_replaced       = 0;
        end else begin
            if (i_cfg_we) pairs_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) patch_request(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (want_patched.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_out_data);
                end else begin
                    want = want_patched.pop_front();
                    if (i_out_data.out_kind !== want.out_kind)
                        report_field("out_kind", 16'(want.out_kind), 16'(i_out_data.out_kind));
                    if (i_out_data.out_byte !== want.out_byte)
                        report_field("out_byte", 16'(want.out_byte), 16'(i_out_data.out_byte));
                    if (i_out_data.match_count !== want.match_count)
                        report_field("match_count", want.match_count, i_out_data.match_count);
                    if (i_out_data.is_last !== want.is_last)
                        report_field("is_last", 16'(want.is_last), 16'(i_out_data.is_last));
                    if (want.out_kind == OUT_COUNT) o_counts_checked++;
                    else o_bytes_checked++;
                end
            end
        end
        o_pending = want_patched.size();
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives buffers and table loads into the pattern replace core with random
// gaps and stalls, and judges by the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
    import ntpr_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         ITEM_GOAL    = 280;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         TAIL_CYCLES  = 24;
    localparam int         HOLD_CYCLES  = 150;
    localparam int         TIMEOUT_NS   = 3_000_000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int bytes_checked;
    int counts_checked;
    int replaced;

    // stimulus-side knowledge of loaded patterns, used to build matching data
    logic [7:0] pat_copy [NUM_PAIRS][MAX_PATTERN_LEN];
    int         pat_len  [NUM_PAIRS];
    logic [7:0] frame_q  [$];

    int item_count  = 0;
    int frames_sent = 0;
    bit steady      = 1'b0;
    bit squeeze_req = 1'b0;
    int hold_left   = 0;

    nul_terminated_pattern_replace_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    patch_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_bytes_checked  (bytes_checked),
        .o_counts_checked (counts_checked),
        .o_replaced       (replaced)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("[nul_terminated_pattern_replace_core] ERROR");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !steady && ($urandom_range(99) < 38);
            end
        end
    end

    task automatic send_request(input t_in_item item);
        while (!steady && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 60) return 8'($urandom_range(8'h41, 8'h44));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_data(input logic [7:0] v, input bit eob);
        t_in_item it;
        it.req_type      = REQ_DATA;
        it.entry_index   = 2'($urandom_range(0, 3));
        it.byte_pos      = 6'($urandom_range(0, 63));
        it.byte_value    = v;
        it.end_of_buffer = eob;
        send_request(it);
        item_count++;
    endtask

    task automatic send_load(input logic [1:0] kind, input int e, input int p,
                             input logic [7:0] v);
        t_in_item it;
        it.req_type      = kind;
        it.entry_index   = 2'(e);
        it.byte_pos      = 6'(p);
        it.byte_value    = v;
        it.end_of_buffer = 1'($urandom_range(0, 1));
        send_request(it);
        item_count++;
    endtask

    // unknown request type or an out-of-range load position
    task automatic send_ignored();
        t_in_item it;
        it.entry_index   = 2'($urandom_range(0, 3));
        it.byte_value    = 8'($urandom_range(0, 255));
        it.end_of_buffer = 1'($urandom_range(0, 1));
        if ($urandom_range(1)) begin
            it.req_type = REQ_UNUSED;
            it.byte_pos = 6'($urandom_range(0, 63));
        end else begin
            it.req_type = $urandom_range(1) ? REQ_PATTERN : REQ_REPLACE;
            it.byte_pos = 6'($urandom_range(MAX_PATTERN_LEN + 1, 63));
        end
        send_request(it);
    endtask

    task automatic load_pair(input int e, input bit force_long);
        int         plen;
        int         rlen;
        int         r;
        logic [7:0] ch;
        r = $urandom_range(99);
        if (force_long)  plen = MAX_PATTERN_LEN;
        else if (r < 65) plen = $urandom_range(1, 4);
        else if (r < 80) plen = $urandom_range(5, 12);
        else if (r < 88) plen = $urandom_range(13, MAX_PATTERN_LEN);
        else if (r < 94) plen = MAX_PATTERN_LEN;
        else             plen = 0;
        rlen = $urandom_range(0, (plen + 3 > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : plen + 3);
        // top-down writes keep both strings readable while they change
        send_load(REQ_REPLACE, e, rlen, 8'h00);
        for (int p = rlen - 1; p >= 0; p--) send_load(REQ_REPLACE, e, p, pick_char());
        if (plen < MAX_PATTERN_LEN) send_load(REQ_PATTERN, e, plen, 8'h00);
        else send_load(REQ_PATTERN, e, MAX_PATTERN_LEN, 8'($urandom_range(0, 255)));
        for (int p = plen - 1; p >= 0; p--) begin
            ch = pick_char();
            pat_copy[e][p] = ch;
            send_load(REQ_PATTERN, e, p, ch);
        end
        pat_len[e] = plen;
    endtask

    // terminated patterns most often, some broken prefixes, zeros and noise
    task automatic build_frame();
        int target;
        int e;
        int r;
        int k;
        frame_q.delete();
        target = ($urandom_range(9) == 0) ? $urandom_range(34, 80) : $urandom_range(1, 36);
        while (frame_q.size() < target) begin
            e = $urandom_range(0, NUM_PAIRS - 1);
            r = $urandom_range(99);
            if (r < 45) begin
                for (int i = 0; i < pat_len[e]; i++) frame_q.push_back(pat_copy[e][i]);
                frame_q.push_back(8'h00);
            end else if (r < 60) begin
                k = $urandom_range(0, pat_len[e]);
                for (int i = 0; i < k; i++) frame_q.push_back(pat_copy[e][i]);
                frame_q.push_back(pick_char());
            end else if (r < 70) begin
                frame_q.push_back(8'h00);
            end else if (r < 85) begin
                frame_q.push_back(pick_char());
            end else begin
                frame_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_frame();
        int cut;
        cut = ($urandom_range(99) < 20) ? $urandom_range(0, frame_q.size() - 1) : -1;
        foreach (frame_q[i]) begin
            // table reload in the middle of a buffer
            if (i == cut) load_pair($urandom_range(0, NUM_PAIRS - 1), 1'b0);
            send_data(frame_q[i], i == frame_q.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int         phase;
        int         nframes;
        logic [2:0] setting;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no pairs in use: data passes untouched, byte extremes
        write_cfg(3'd0);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        send_ignored();
        send_ignored();
        // pair 0 with a replacement longer than its pattern, pair 1 empty
        send_load(REQ_REPLACE, 0, 3, 8'h00);
        send_load(REQ_REPLACE, 0, 2, 8'h03);
        send_load(REQ_REPLACE, 0, 1, 8'h02);
        send_load(REQ_REPLACE, 0, 0, 8'h01);
        send_load(REQ_PATTERN, 0, 2, 8'h00);
        send_load(REQ_PATTERN, 0, 1, 8'hBB);
        send_load(REQ_PATTERN, 0, 0, 8'hAA);
        send_load(REQ_PATTERN, 1, 0, 8'h00);
        pat_copy[0][0] = 8'hAA;
        pat_copy[0][1] = 8'hBB;
        pat_len[0]     = 2;
        pat_len[1]     = 0;
        wait_drained();
        write_cfg(3'd2);
        // two matches, then the pattern at the buffer end with no terminator
        send_data(8'hAA, 1'b0);
        send_data(8'hBB, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'hAA, 1'b0);
        send_data(8'hBB, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'hAA, 1'b0);
        send_data(8'hBB, 1'b1);

        // pairs 2 and 3 are loaded before any setting uses them
        load_pair(2, 1'b0);
        load_pair(3, 1'b0);

        phase = 0;
        while (item_count < ITEM_GOAL || phase < 3) begin
            case (phase)
                0:       setting = 3'd4;
                1:       setting = 3'd7;
                2:       setting = 3'd0;
                default: setting = 3'($urandom_range(0, 7));
            endcase
            wait_drained();
            write_cfg(setting);
            steady  = (phase == 1);
            nframes = $urandom_range(1, 3);
            if (phase == 1) load_pair(0, 1'b1);
            if (phase == 2) begin
                squeeze_req = 1'b1;
                nframes     = 3;
            end
            repeat (nframes) begin
                if ($urandom_range(99) < 20) send_ignored();
                if ($urandom_range(99) < 25) load_pair($urandom_range(0, NUM_PAIRS - 1), 1'b0);
                build_frame();
                send_frame();
            end
            phase++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("covered %0d requests in %0d buffers over %0d pair settings,",
                 item_count, frames_sent + 2, phase + 2);
        $display("checked %0d patched bytes and %0d counts holding %0d replacements",
                 bytes_checked, counts_checked, replaced);
        if (fail_count == 0 && pending == 0) begin
            $display("[nul_terminated_pattern_replace_core] OK");
        end else begin
            $display("[nul_terminated_pattern_replace_core] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ntpr_pkg.sv
sv/ntpr_front.sv
sv/ntpr_queue.sv
sv/ntpr_back.sv
sv/nul_terminated_pattern_replace_core.sv
sv/ntpr_checker.sv
verif/patch_checker.sv
verif/testbench.sv
